[hw/rtl/button_edge_hold_repeat_tracker_unit_defines.svh]
// Assertion macros shared by the tracker RTL.
`ifndef BUTTON_EDGE_HOLD_REPEAT_TRACKER_UNIT_DEFINES_SVH
`define BUTTON_EDGE_HOLD_REPEAT_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BEHRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define BEHRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/behrt_pkg.sv]
// Shared types and constants of the button tracker.
package behrt_pkg;

  localparam int unsigned RAW_W     = 8;
  localparam int unsigned DT_W      = 10;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned REL_W     = 32;
  localparam int unsigned ACC_W     = 10;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned BIDX_W    = 3;
  localparam int unsigned CODE_W    = 4;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned PER_W     = 10;
  localparam int unsigned DLY_W     = 10;
  localparam int unsigned COMBO_W   = 40;
  localparam int unsigned COMBO_MAX = 16;   // nibbles addressable by the matcher
  localparam int unsigned WIN_W     = 12;   // holds 2*1023+5
  localparam int unsigned WIN_BASE  = 5;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;

  localparam int unsigned NUM_BUTTONS_DEF   = 8;
  localparam int unsigned HISTORY_DEPTH_DEF = 10;

  localparam logic [THR_W-1:0] THR_RST = THR_W'(500);
  localparam logic [PER_W-1:0] PER_RST = PER_W'(100);
  localparam logic [DLY_W-1:0] DLY_RST = DLY_W'(150);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_THRESHOLD = 2'd0,
    REG_REPEAT_PERIOD  = 2'd1,
    REG_REPEAT_DELAY   = 2'd2,
    REG_COMBO_CODE     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_buttons;
    logic [DT_W-1:0]  elapsed_ms;
    logic             orientation_down;
    logic             clear_request;
  } in_item_t;

  typedef struct packed {
    logic [BIDX_W-1:0] button_index;
    logic              is_down;
    logic              pressed_edge;
    logic              released_edge;
    logic              held_flag;
    logic              repeat_fire;
    logic [HOLD_W-1:0] down_time_ms;
    logic [REL_W-1:0]  up_time_ms;
    logic [CNT_W-1:0]  frame_count;
    logic              combo_match;
    logic              last_result;
  } out_item_t;

endpackage

[hw/rtl/behrt_ifs.sv]
// Valid/ready stream interfaces for tick items and button results.
interface behrt_in_if;
  import behrt_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface behrt_out_if;
  import behrt_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/button_edge_hold_repeat_tracker_unit.sv]
// Button edge, hold, auto-repeat and combo tracker, top level.
//
// Usage:
//   in_ch  (sink)   one item per tick: raw button mask, elapsed ms, orientation
//                   flag and clear request. Accepted when valid && ready.
//   out_ch (source) NUM_BUTTONS results per tick, button 0 first; the last one
//                   carries last_result = 1.
//   cfg_*           write-only registers: hold threshold, repeat period,
//                   repeat delay, combo code. Write only while the block idles.
// Timing: an accepted item waits in the input register until it commits, which
//   updates state, history and repeat window together; its results then leave
//   through the output register, one result per cycle while out_ch.ready is high.
// Sequencing: the result sequencer walks the buttons one per cycle while
//   out_ch.ready is high, NUM_BUTTONS results per tick. The input register
//   takes the next tick while results are still going out.
// Reset: timers, masks, counters cleared, history filled with the empty code,
//   registers back to 500/100/150/0. No clearing pass.
// Stall: when out_ch.ready is low the current result holds in the output
//   register, the sequencer pauses, and one more tick can wait in the input
//   register before in_ch.ready drops.
module button_edge_hold_repeat_tracker_unit #(
  parameter int unsigned NUM_BUTTONS   = behrt_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned HISTORY_DEPTH = behrt_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  behrt_in_if.sink                          in_ch,
  behrt_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [behrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [behrt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import behrt_pkg::*;

`include "button_edge_hold_repeat_tracker_unit_defines.svh"

  localparam int unsigned IDX_W  = $clog2(NUM_BUTTONS);
  localparam int unsigned HEAD_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned RANK_W = $clog2(NUM_BUTTONS + 1);
  localparam int unsigned SUM_W  = $clog2(HISTORY_DEPTH + NUM_BUTTONS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  // ---------------- configuration registers
  logic [THR_W-1:0]   thr_r;
  logic [PER_W-1:0]   period_r;
  logic [DLY_W-1:0]   delay_r;
  logic [COMBO_W-1:0] combo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RST;
      period_r <= PER_RST;
      delay_r  <= DLY_RST;
      combo_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HOLD_THRESHOLD: thr_r    <= cfg_wdata[THR_W-1:0];
        REG_REPEAT_PERIOD:  period_r <= cfg_wdata[PER_W-1:0];
        REG_REPEAT_DELAY:   delay_r  <= cfg_wdata[DLY_W-1:0];
        REG_COMBO_CODE:     combo_r  <= cfg_wdata[COMBO_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input register
  logic     in_valid_r;
  in_item_t in_data_r;
  logic     in_ready;
  logic     commit;

  assign in_ready    = !in_valid_r || commit;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (commit) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      in_data_r <= in_ch.data;
    end
  end

  // ---------------- result sequencer control
  logic             busy_r;
  logic [IDX_W-1:0] emit_idx_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic             load;
  logic             last_load;

  assign load      = busy_r && (!out_valid_r || out_ch.ready);
  assign last_load = load && (emit_idx_r == LAST_IDX);
  // A tick commits once the previous tick's last result leaves the state.
  assign commit    = in_valid_r && (!busy_r || last_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      emit_idx_r <= '0;
    end else if (commit) begin
      busy_r     <= 1'b1;
      emit_idx_r <= '0;
    end else if (load) begin
      busy_r     <= !last_load;
      emit_idx_r <= IDX_W'(emit_idx_r + 1'b1);
    end
  end

  // ---------------- tracker state
  logic [NUM_BUTTONS-1:0] down_r;
  logic [NUM_BUTTONS-1:0] prev_r;
  logic [NUM_BUTTONS-1:0] supp_r;
  logic                   clr_r;     // clear from the last committed tick
  logic [WIN_W-1:0]       window_r;
  logic [HOLD_W-1:0]      hold_r [NUM_BUTTONS];
  logic [REL_W-1:0]       rel_r  [NUM_BUTTONS];
  logic [ACC_W-1:0]       acc_r  [NUM_BUTTONS];
  logic [CNT_W-1:0]       cnt_r  [NUM_BUTTONS];
  logic [CODE_W-1:0]      hist_r [HISTORY_DEPTH];
  logic [HEAD_W-1:0]      head_r;

  logic [NUM_BUTTONS-1:0] down_nxt;
  logic [NUM_BUTTONS-1:0] prev_nxt;
  logic [NUM_BUTTONS-1:0] supp_nxt;
  logic [WIN_W-1:0]       window_nxt;
  logic [HOLD_W-1:0]      hold_nxt [NUM_BUTTONS];
  logic [REL_W-1:0]       rel_nxt  [NUM_BUTTONS];
  logic [ACC_W-1:0]       acc_nxt  [NUM_BUTTONS];
  logic [CNT_W-1:0]       cnt_nxt  [NUM_BUTTONS];
  logic [CODE_W-1:0]      hist_nxt [HISTORY_DEPTH];
  logic [HEAD_W-1:0]      head_nxt;

  logic [RAW_W-1:0]       raw_sw;
  logic [NUM_BUTTONS-1:0] raw_n;
  logic [NUM_BUTTONS-1:0] down_eff;
  logic [NUM_BUTTONS-1:0] supp_eff;
  logic [NUM_BUTTONS-1:0] press;
  logic [RANK_W-1:0]      rank [NUM_BUTTONS];
  logic [RANK_W-1:0]      total;
  logic [HEAD_W-1:0]      pos  [NUM_BUTTONS];
  logic [HOLD_W:0]        hold_sum [NUM_BUTTONS];
  logic [REL_W:0]         rel_sum  [NUM_BUTTONS];
  logic [ACC_W:0]         acc_sum  [NUM_BUTTONS];
  logic [WIN_W-1:0]       win_base;

  // Flipped screen: A<->B, start<->select, up<->down, right<->left.
  function automatic logic [RAW_W-1:0] flip_pairs(input logic [RAW_W-1:0] m);
    return {m[5], m[4], m[7], m[6], m[2], m[3], m[0], m[1]};
  endfunction

  // Ring wrap of a small sum: constant lookup table.
  function automatic logic [HEAD_W-1:0] ring_wrap(input logic [SUM_W-1:0] x);
    logic [HEAD_W-1:0] r;
    r = '0;
    for (int j = 0; j < (1 << SUM_W); j++) begin
      if (x == SUM_W'(j)) r = HEAD_W'(j % HISTORY_DEPTH);
    end
    return r;
  endfunction

  always_comb begin
    raw_sw   = in_data_r.orientation_down ? flip_pairs(in_data_r.raw_buttons)
                                          : in_data_r.raw_buttons;
    raw_n    = NUM_BUTTONS'(raw_sw);     // buttons past the raw mask read up
    // pending clear from the previous tick lands here
    down_eff = clr_r ? '0 : down_r;
    supp_eff = clr_r ? '1 : supp_r;
    supp_nxt = raw_n & supp_eff;
    down_nxt = raw_n & ~supp_eff;
    prev_nxt = down_eff;
    press    = down_nxt & ~down_eff;

    for (int i = 0; i < NUM_BUTTONS; i++) begin
      hold_sum[i] = {1'b0, hold_r[i]} + (HOLD_W+1)'(in_data_r.elapsed_ms);
      rel_sum[i]  = {1'b0, rel_r[i]} + (REL_W+1)'(in_data_r.elapsed_ms);
      acc_sum[i]  = {1'b0, acc_r[i]} + (ACC_W+1)'(in_data_r.elapsed_ms);
      if (down_nxt[i]) begin
        hold_nxt[i] = hold_sum[i][HOLD_W] ? '1 : hold_sum[i][HOLD_W-1:0];
        rel_nxt[i]  = '0;
        acc_nxt[i]  = (acc_sum[i] >= (ACC_W+1)'(period_r)) ? '0 : acc_sum[i][ACC_W-1:0];
        cnt_nxt[i]  = cnt_r[i] + 1'b1;
      end else begin
        hold_nxt[i] = '0;
        rel_nxt[i]  = rel_sum[i][REL_W] ? '1 : rel_sum[i][REL_W-1:0];
        acc_nxt[i]  = '0;
        cnt_nxt[i]  = '0;
      end
    end

    // press order = button order; each press takes the next ring slot
    total = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < NUM_BUTTONS; j++) begin
        if (j < i && press[j]) rank[i] = rank[i] + 1'b1;
      end
      if (press[i]) total = total + 1'b1;
      pos[i] = ring_wrap(SUM_W'(head_r) + SUM_W'(rank[i]));
    end
    for (int s = 0; s < HISTORY_DEPTH; s++) begin
      hist_nxt[s] = hist_r[s];
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (press[i] && pos[i] == HEAD_W'(s)) hist_nxt[s] = CODE_W'(i);
      end
    end
    head_nxt = ring_wrap(SUM_W'(head_r) + SUM_W'(total));

    win_base   = WIN_W'({in_data_r.elapsed_ms, 1'b0}) + WIN_W'(WIN_BASE);
    window_nxt = (win_base < WIN_W'(delay_r)) ? WIN_W'(delay_r) : win_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_r   <= '0;
      prev_r   <= '0;
      supp_r   <= '0;
      clr_r    <= 1'b0;
      window_r <= '0;
      head_r   <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hold_r[i] <= '0;
        rel_r[i]  <= '0;
        acc_r[i]  <= '0;
        cnt_r[i]  <= '0;
      end
      for (int s = 0; s < HISTORY_DEPTH; s++) begin
        hist_r[s] <= CODE_W'(NUM_BUTTONS);
      end
    end else if (commit) begin
      down_r   <= down_nxt;
      prev_r   <= prev_nxt;
      supp_r   <= supp_nxt;
      clr_r    <= in_data_r.clear_request;
      window_r <= window_nxt;
      head_r   <= head_nxt;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hold_r[i] <= hold_nxt[i];
        rel_r[i]  <= rel_nxt[i];
        acc_r[i]  <= acc_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
      for (int s = 0; s < HISTORY_DEPTH; s++) begin
        hist_r[s] <= hist_nxt[s];
      end
    end
  end

  // ---------------- combo match over the ring, oldest entry first
  logic [CODE_W*COMBO_MAX-1:0] combo_ext;
  logic [HEAD_W:0]             ring_sum;
  logic                        match;

  always_comb begin
    combo_ext = (CODE_W*COMBO_MAX)'(combo_r);
    match     = 1'b1;
    ring_sum  = '0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      ring_sum = {1'b0, head_r} + (HEAD_W+1)'(k);
      if (ring_sum >= (HEAD_W+1)'(HISTORY_DEPTH)) begin
        ring_sum = ring_sum - (HEAD_W+1)'(HISTORY_DEPTH);
      end
      if (hist_r[ring_sum[HEAD_W-1:0]] != combo_ext[CODE_W*k +: CODE_W]) match = 1'b0;
    end
  end

  // ---------------- per-button result
  out_item_t out_nxt;
  logic      cur_d;
  logic      cur_p;

  always_comb begin
    cur_d = down_r[emit_idx_r];
    cur_p = prev_r[emit_idx_r];
    out_nxt.button_index  = emit_idx_r[BIDX_W-1:0];
    out_nxt.is_down       = cur_d;
    out_nxt.pressed_edge  = cur_d && !cur_p;
    out_nxt.released_edge = !cur_d && cur_p;
    out_nxt.held_flag     = cur_d && (hold_r[emit_idx_r] >= thr_r);
    if (!cur_d) begin
      out_nxt.repeat_fire = 1'b0;
    end else if (hold_r[emit_idx_r] < HOLD_W'(window_r)) begin
      out_nxt.repeat_fire = !cur_p;    // early in the press: fire on the edge only
    end else begin
      out_nxt.repeat_fire = (acc_r[emit_idx_r] == '0);
    end
    out_nxt.down_time_ms  = hold_r[emit_idx_r];
    out_nxt.up_time_ms    = rel_r[emit_idx_r];
    out_nxt.frame_count   = cnt_r[emit_idx_r];
    out_nxt.combo_match   = match;
    out_nxt.last_result   = (emit_idx_r == LAST_IDX);
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // ---------------- assertions
  `BEHRT_ASSERT_NEXT(a_commit_starts_walk, commit, busy_r && (emit_idx_r == '0), "walk did not restart on commit")
  `BEHRT_ASSERT_NEXT(a_walk_steps, load && !last_load, busy_r && (emit_idx_r == IDX_W'($past(emit_idx_r) + 1'b1)), "result walk skipped a button")
  `BEHRT_ASSERT_NOW(a_head_in_ring, 1'b1, int'(head_r) < HISTORY_DEPTH, "history head out of ring")
  `BEHRT_ASSERT_NEXT(a_pending_tick_holds, in_valid_r && !commit, in_valid_r && $stable(in_data_r), "pending tick lost")

endmodule

[bench/button_tracker_checker.sv]
// Scoreboard for the button tracker: mirrors per-button state and checks every result.
module button_tracker_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  behrt_in_if                              tick_ch,
  behrt_out_if                             result_ch,
  input  logic                             cfg_we,
  input  logic [behrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [behrt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                      fail_count,
  output int unsigned                      awaiting
);
  import behrt_pkg::*;

  localparam int unsigned NB = NUM_BUTTONS_DEF;
  localparam int unsigned HD = HISTORY_DEPTH_DEF;

  logic [THR_W-1:0]   hold_thr;
  logic [PER_W-1:0]   rep_period;
  logic [DLY_W-1:0]   rep_delay;
  logic [COMBO_W-1:0] combo;

  logic [RAW_W-1:0]  down_m;
  logic [RAW_W-1:0]  prev_m;
  logic [RAW_W-1:0]  supp_m;
  logic [HOLD_W-1:0] down_ms [NB];
  logic [REL_W-1:0]  up_ms [NB];
  logic [ACC_W-1:0]  rep_acc [NB];
  logic [CNT_W-1:0]  frames [NB];
  logic [CODE_W-1:0] press_ring [HD];
  int unsigned       ring_head;

  out_item_t button_results_q[$];

  // One tick: update button state, push the NB results it produces.
  task automatic tick_update(input in_item_t it);
    logic [RAW_W-1:0]  raw;
    logic [DT_W-1:0]   dt;
    logic [HOLD_W:0]   hsum;
    logic [REL_W:0]    rsum;
    logic [ACC_W:0]    asum;
    logic [WIN_W-1:0]  window;
    logic              now;
    logic              rep;
    logic              match;
    out_item_t         r;
    raw = it.raw_buttons;
    dt  = it.elapsed_ms;
    // flipped screen: up<->down, right<->left, A<->B, start<->select
    if (it.orientation_down) begin
      raw = {raw[5], raw[4], raw[7], raw[6], raw[2], raw[3], raw[0], raw[1]};
    end
    for (int i = 0; i < NB; i++) begin
      now = raw[i];
      if (!now) supp_m[i] = 1'b0;
      if (supp_m[i]) now = 1'b0;
      prev_m[i] = down_m[i];
      down_m[i] = now;
      if (!now) begin
        down_ms[i] = '0;
        rsum       = {1'b0, up_ms[i]} + dt;
        up_ms[i]   = rsum[REL_W] ? '1 : rsum[REL_W-1:0];
        rep_acc[i] = '0;
        frames[i]  = '0;
      end else begin
        hsum       = {1'b0, down_ms[i]} + dt;
        down_ms[i] = hsum[HOLD_W] ? '1 : hsum[HOLD_W-1:0];
        up_ms[i]   = '0;
        asum       = {1'b0, rep_acc[i]} + dt;
        rep_acc[i] = (asum >= rep_period) ? '0 : asum[ACC_W-1:0];
        frames[i]  = frames[i] + 1'b1;
      end
    end
    for (int i = 0; i < NB; i++) begin
      if (down_m[i] && !prev_m[i]) begin
        press_ring[ring_head] = CODE_W'(i);
        ring_head = (ring_head + 1 == HD) ? 0 : ring_head + 1;
      end
    end
    match = 1'b1;
    for (int k = 0; k < HD; k++) begin
      if (press_ring[(ring_head + k) % HD] != combo[CODE_W*k +: CODE_W]) match = 1'b0;
    end
    window = {1'b0, dt, 1'b0} + WIN_W'(WIN_BASE);
    if (window < rep_delay) window = WIN_W'(rep_delay);
    for (int i = 0; i < NB; i++) begin
      rep = 1'b0;
      if (down_m[i]) rep = (down_ms[i] < window) ? !prev_m[i] : (rep_acc[i] == '0);
      r.button_index  = BIDX_W'(i);
      r.is_down       = down_m[i];
      r.pressed_edge  = down_m[i] && !prev_m[i];
      r.released_edge = !down_m[i] && prev_m[i];
      r.held_flag     = down_m[i] && (down_ms[i] >= hold_thr);
      r.repeat_fire   = rep;
      r.down_time_ms  = down_ms[i];
      r.up_time_ms    = up_ms[i];
      r.frame_count   = frames[i];
      r.combo_match   = match;
      r.last_result   = (i == NB - 1);
      button_results_q.push_back(r);
    end
    // clear lands after this tick's results
    if (it.clear_request) begin
      down_m = '0;
      supp_m = '1;
    end
  endtask

  task automatic check_field(input string what, input logic [BIDX_W-1:0] btn,
                             input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: button %0d %s: expected %0h, actual %0h", $time, btn, what, want, got);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (button_results_q.size() == 0) begin
      fail_count++;
      $display("%0t: result with none pending: expected none, actual %p", $time, got);
    end else begin
      want = button_results_q.pop_front();
      check_field("button_index", want.button_index, want.button_index, got.button_index);
      check_field("is_down", want.button_index, want.is_down, got.is_down);
      check_field("pressed_edge", want.button_index, want.pressed_edge, got.pressed_edge);
      check_field("released_edge", want.button_index, want.released_edge, got.released_edge);
      check_field("held_flag", want.button_index, want.held_flag, got.held_flag);
      check_field("repeat_fire", want.button_index, want.repeat_fire, got.repeat_fire);
      check_field("down_time_ms", want.button_index, want.down_time_ms, got.down_time_ms);
      check_field("up_time_ms", want.button_index, want.up_time_ms, got.up_time_ms);
      check_field("frame_count", want.button_index, want.frame_count, got.frame_count);
      check_field("combo_match", want.button_index, want.combo_match, got.combo_match);
      check_field("last_result", want.button_index, want.last_result, got.last_result);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_thr   = THR_RST;
      rep_period = PER_RST;
      rep_delay  = DLY_RST;
      combo      = '0;
      down_m     = '0;
      prev_m     = '0;
      supp_m     = '0;
      for (int i = 0; i < NB; i++) begin
        down_ms[i] = '0;
        up_ms[i]   = '0;
        rep_acc[i] = '0;
        frames[i]  = '0;
      end
      for (int k = 0; k < HD; k++) press_ring[k] = CODE_W'(NB);
      ring_head = 0;
      button_results_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HOLD_THRESHOLD: hold_thr   = cfg_wdata[THR_W-1:0];
          REG_REPEAT_PERIOD:  rep_period = cfg_wdata[PER_W-1:0];
          REG_REPEAT_DELAY:   rep_delay  = cfg_wdata[DLY_W-1:0];
          REG_COMBO_CODE:     combo      = cfg_wdata[COMBO_W-1:0];
          default: ;
        endcase
      end
      if (tick_ch.valid && tick_ch.ready) tick_update(tick_ch.data);
      if (result_ch.valid && result_ch.ready) check_result(result_ch.data);
    end
    awaiting = button_results_q.size();
  end

endmodule

[bench/tb.sv]
// Top of the button tracker bench: clock, reset, tick stimulus, register phases, verdict.
module tb;
  import behrt_pkg::*;

  localparam int unsigned NB          = NUM_BUTTONS_DEF;
  localparam int unsigned HD          = HISTORY_DEPTH_DEF;
  // Cycle budget for the whole run; the watchdog below fails the run past it.
  localparam int unsigned CYCLE_LIMIT = 100000;
  // Idle edges that drain() waits after the last result has come back.
  localparam int unsigned SETTLE      = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    stall_en;
  int unsigned           fail_count;
  int unsigned           awaiting;
  int unsigned           cycle_count;
  logic [CODE_W-1:0]     combo_seq [HD];

  behrt_in_if  tick_ch();
  behrt_out_if result_ch();

  button_edge_hold_repeat_tracker_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (tick_ch),
    .out_ch    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  button_tracker_checker i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_ch    (tick_ch),
    .result_ch  (result_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .awaiting   (awaiting)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side backpressure: ~8% stall cycles while stall_en is set.
  always @(posedge clk) begin
    result_ch.ready <= !stall_en || ($urandom_range(0, 99) >= 8);
  end

  // Hard stop if the block hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic in_item_t make_tick(input logic [RAW_W-1:0] raw,
                                         input logic [DT_W-1:0] dt,
                                         input logic flip, input logic clr);
    in_item_t t;
    t.raw_buttons      = raw;
    t.elapsed_ms       = dt;
    t.orientation_down = flip;
    t.clear_request    = clr;
    return t;
  endfunction

  // Offer one tick item, with an occasional short gap first; valid stays high
  // after acceptance so back-to-back items need no extra assignment.
  task automatic send_tick(input in_item_t it);
    int unsigned gap;
    if (stall_en && $urandom_range(0, 99) < 8) begin
      gap = $urandom_range(1, 3);
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= it;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  // Drop valid, wait until every pending result has come back, then settle.
  task automatic drain();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Back-to-back register writes with write enable held; junk above each
  // narrow register's width checks that the block masks it off.
  task automatic load_regs(input logic [THR_W-1:0] thr, input logic [PER_W-1:0] per,
                           input logic [DLY_W-1:0] dly, input logic [COMBO_W-1:0] cmb);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    cfg_we    <= 1'b1;
    cfg_index <= REG_HOLD_THRESHOLD;
    cfg_wdata <= {junk[CFG_DATA_W-1:THR_W], thr};
    @(posedge clk);
    cfg_index <= REG_REPEAT_PERIOD;
    cfg_wdata <= {junk[CFG_DATA_W-1:PER_W], per};
    @(posedge clk);
    cfg_index <= REG_REPEAT_DELAY;
    cfg_wdata <= {junk[CFG_DATA_W-1:DLY_W], dly};
    @(posedge clk);
    cfg_index <= REG_COMBO_CODE;
    cfg_wdata <= cmb;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [THR_W-1:0]   thr;
    logic [PER_W-1:0]   per;
    logic [DLY_W-1:0]   dly;
    logic [COMBO_W-1:0] cmb;
    logic [RAW_W-1:0]   mask;
    logic [DT_W-1:0]    dt;
    logic               flip;
    int unsigned        hold_len;

    rst_n           <= 1'b0;
    stall_en        <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_HOLD_THRESHOLD;
    cfg_wdata       <= '0;
    tick_ch.valid   <= 1'b0;
    tick_ch.data    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed ticks, reset register values (500 / 100 / 150 / 0) ----
    send_tick(make_tick(8'h00, 10'd0, 1'b0, 1'b0));     // all idle, zero dt
    send_tick(make_tick(8'hFF, 10'd0, 1'b0, 1'b0));     // all pressed: edge fires repeat
    send_tick(make_tick(8'hFF, 10'd1023, 1'b0, 1'b0));  // inside the 2*dt+5 window
    send_tick(make_tick(8'hFF, 10'd1023, 1'b0, 1'b0));
    send_tick(make_tick(8'hFF, 10'd1023, 1'b0, 1'b0));  // past window: held, acc-driven
    send_tick(make_tick(8'h00, 10'd1023, 1'b0, 1'b0));  // release edges
    send_tick(make_tick(8'h00, 10'd1023, 1'b0, 1'b0));  // up time grows
    send_tick(make_tick(8'h55, 10'd7, 1'b1, 1'b0));     // flipped screen swaps pairs
    send_tick(make_tick(8'hAA, 10'd13, 1'b1, 1'b0));
    send_tick(make_tick(8'h0F, 10'd40, 1'b0, 1'b0));
    send_tick(make_tick(8'hF0, 10'd40, 1'b1, 1'b0));
    send_tick(make_tick(8'hFF, 10'd1, 1'b0, 1'b1));     // clear while held
    send_tick(make_tick(8'hFF, 10'd2, 1'b0, 1'b0));     // everything suppressed
    send_tick(make_tick(8'h0F, 10'd3, 1'b0, 1'b0));     // upper half lets go -> unsuppressed
    send_tick(make_tick(8'hFF, 10'd4, 1'b0, 1'b0));     // upper presses, lower still masked
    send_tick(make_tick(8'h00, 10'd5, 1'b0, 1'b1));     // clear while all up
    send_tick(make_tick(8'h3C, 10'd512, 1'b1, 1'b1));   // clear with flip, still suppressed
    send_tick(make_tick(8'h00, 10'd6, 1'b0, 1'b0));     // suppression ends
    drain();

    // ---- Register phases: combo entry, a held stretch, then noise ----
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < HD; k++) combo_seq[k] = CODE_W'($urandom_range(0, NB - 1));
      cmb = '0;
      for (int k = 0; k < HD; k++) cmb[CODE_W*k +: CODE_W] = combo_seq[k];
      case (p)
        0: begin
          // low extremes, combo reachable
          thr = '0;
          per = PER_W'(1);
          dly = '0;
        end
        1: begin
          // high extremes; all-F combo can never match
          thr = '1;
          per = '1;
          dly = '1;
          cmb = '1;
        end
        2: begin
          // zero period: accumulator cleared every down tick; no idling here
          thr = THR_W'($urandom_range(0, 2000));
          per = '0;
          dly = DLY_W'($urandom_range(0, 1023));
          stall_en <= 1'b0;
        end
        default: begin
          thr = THR_W'($urandom);
          per = PER_W'($urandom_range(1, 1023));
          dly = DLY_W'($urandom);
          cmb = COMBO_W'({$urandom, $urandom});
        end
      endcase
      load_regs(thr, per, dly, cmb);

      // Combo: one press per tick; a release tick first and between repeats
      // so every press is a real edge.
      send_tick(make_tick(8'h00, DT_W'($urandom_range(0, 200)), 1'b0, 1'b0));
      for (int k = 0; k < HD; k++) begin
        if (k > 0 && combo_seq[k] == combo_seq[k-1]) begin
          send_tick(make_tick(8'h00, DT_W'($urandom_range(0, 200)), 1'b0, 1'b0));
        end
        send_tick(make_tick(RAW_W'(1) << combo_seq[k], DT_W'($urandom_range(0, 200)),
                            1'b0, 1'b0));
      end

      // Held stretch: repeat and hold behavior. Phase 1 runs long at max dt so
      // down time saturates and the max threshold is reached.
      hold_len = (p == 1) ? 68 : 10;
      mask     = RAW_W'($urandom_range(1, 255));
      flip     = 1'($urandom);
      for (int h = 0; h < hold_len; h++) begin
        if (p != 1 && $urandom_range(0, 3) == 0) mask ^= RAW_W'(1) << $urandom_range(0, 7);
        if (p == 1) dt = '1;
        else if ($urandom_range(0, 9) == 0) dt = DT_W'($urandom);
        else dt = DT_W'($urandom_range(0, 120));
        send_tick(make_tick(mask, dt, flip, 1'b0));
      end

      // Noise, with the odd clear
      repeat (3) begin
        send_tick(make_tick(RAW_W'($urandom), DT_W'($urandom), 1'($urandom),
                            $urandom_range(0, 5) == 0));
      end
      drain();
      // idling comes back after the no-idle phase
      if (p == 2) stall_en <= 1'b1;
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/behrt_pkg.sv
hw/rtl/behrt_ifs.sv
hw/rtl/button_edge_hold_repeat_tracker_unit.sv
bench/button_tracker_checker.sv
bench/tb.sv
